[hdl/rmf_pkg.sv]
// Shared constants and types for the running median filter.
package rmf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WINDOW_DEF = 9;

    // Status that a cell reports about itself.
    typedef struct packed {
        logic g;    // cell sorts after the new request (or is empty)
        logic del;  // cell holds the oldest sample and is being dropped
    } cell_ctl_t;

    // Neighbor and global context that steers a cell's move.
    typedef struct packed {
        logic valid;
        logic full;
        logic g_prev;
        logic g_next;
        logic dle_prev;
        logic dle_self;
        logic del_lo;
    } cell_nbr_t;

endpackage

[hdl/rmf_cell.sv]
// One cell of the sorted window: a sample and its age, moved or kept each update.
module rmf_cell #(
    parameter int AGE_W = 4
) (
    input  logic                                aclk,
    input  logic                                update,
    input  logic signed [rmf_pkg::SAMPLE_W-1:0] x,
    input  rmf_pkg::cell_nbr_t                  nbr,
    input  logic signed [rmf_pkg::SAMPLE_W-1:0] left_value,
    input  logic        [AGE_W-1:0]             left_age,
    input  logic signed [rmf_pkg::SAMPLE_W-1:0] right_value,
    input  logic        [AGE_W-1:0]             right_age,
    input  logic        [AGE_W-1:0]             oldest_age,
    output logic signed [rmf_pkg::SAMPLE_W-1:0] value,
    output logic        [AGE_W-1:0]             age,
    output rmf_pkg::cell_ctl_t                  ctl
);

    logic signed [rmf_pkg::SAMPLE_W-1:0] value_reg, value_next;
    logic        [AGE_W-1:0]             age_reg, age_next;

    always_comb begin
        ctl.g   = !nbr.valid || (value_reg > x);
        ctl.del = nbr.full && nbr.valid && (age_reg == oldest_age);
    end

    always_comb begin
        value_next = value_reg;
        age_next   = age_reg + AGE_W'(1);
        if (!ctl.g) begin
            if (nbr.del_lo && nbr.dle_self) begin
                if (nbr.g_next) begin
                    value_next = x;
                    age_next   = '0;
                end else begin
                    value_next = right_value;
                    age_next   = right_age + AGE_W'(1);
                end
            end
        end else if (!nbr.del_lo) begin
            if (!nbr.g_prev) begin
                value_next = x;
                age_next   = '0;
            end else if (!nbr.dle_prev) begin
                value_next = left_value;
                age_next   = left_age + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

[hdl/running_median_filter.sv]
// Throughput: one sample per cycle while the output is not stalled by m_tready;
// the sorted cell row drops the oldest sample and inserts the new one in a
// single update, then the median cell is registered onto m_tdata.
// Reset: aresetn low empties the window (fill count 0) and clears the busy and
// output valid flags; cell contents are not cleared and are ignored until written.
module running_median_filter #(
    parameter int WINDOW = rmf_pkg::WINDOW_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rmf_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rmf_pkg::SAMPLE_W-1:0] m_tdata    // [15:0] median
);

    localparam int AGE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = AGE_W;

    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic                         busy_reg, busy_next;
    logic                         m_valid_reg, m_valid_next;
    logic [rmf_pkg::SAMPLE_W-1:0] med_reg, med_next;

    logic signed [rmf_pkg::SAMPLE_W-1:0] x;
    logic signed [rmf_pkg::SAMPLE_W-1:0] cell_value [WINDOW];
    logic        [AGE_W-1:0]             cell_age   [WINDOW];
    rmf_pkg::cell_ctl_t                  cell_ctl   [WINDOW];
    rmf_pkg::cell_nbr_t                  cell_nbr   [WINDOW];
    logic [WINDOW-1:0]                   dle;
    logic                                del_lo;
    logic                                full;
    logic                                accept;
    logic                                load;
    logic [CNT_W-1:0]                    mid_cnt;

    assign x        = $signed(s_tdata);
    assign full     = (fill_reg == CNT_W'(WINDOW));
    assign load     = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready = !busy_reg || load;
    assign accept   = s_tvalid && s_tready;

    // prefix of the drop flag and whether the dropped cell sorts at or below the new sample
    always_comb begin
        del_lo = 1'b0;
        for (int i = 0; i < WINDOW; i++) begin
            if (i == 0) begin
                dle[i] = cell_ctl[i].del;
            end else begin
                dle[i] = dle[i-1] | cell_ctl[i].del;
            end
            del_lo = del_lo | (cell_ctl[i].del & !cell_ctl[i].g);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            logic signed [rmf_pkg::SAMPLE_W-1:0] lv, rv;
            logic        [AGE_W-1:0]             la, ra;
            logic                                gp, dp, gn;

            assign cell_nbr[gi] = '{
                valid:    (fill_reg > CNT_W'(gi)),
                full:     full,
                g_prev:   gp,
                g_next:   gn,
                dle_prev: dp,
                dle_self: dle[gi],
                del_lo:   del_lo
            };

            if (gi == 0) begin : g_first
                assign gp = 1'b0;
                assign dp = 1'b0;
                assign lv = cell_value[gi];
                assign la = cell_age[gi];
            end else begin : g_mid_l
                assign gp = cell_ctl[gi-1].g;
                assign dp = dle[gi-1];
                assign lv = cell_value[gi-1];
                assign la = cell_age[gi-1];
            end

            if (gi == WINDOW - 1) begin : g_last
                assign gn = 1'b1;
                assign rv = cell_value[gi];
                assign ra = cell_age[gi];
            end else begin : g_mid_r
                assign gn = cell_ctl[gi+1].g;
                assign rv = cell_value[gi+1];
                assign ra = cell_age[gi+1];
            end

            rmf_cell #(
                .AGE_W(AGE_W)
            ) u_cell (
                .aclk       (aclk),
                .update     (accept),
                .x          (x),
                .nbr        (cell_nbr[gi]),
                .left_value (lv),
                .left_age   (la),
                .right_value(rv),
                .right_age  (ra),
                .oldest_age (AGE_W'(WINDOW - 1)),
                .value      (cell_value[gi]),
                .age        (cell_age[gi]),
                .ctl        (cell_ctl[gi])
            );
        end
    endgenerate

    assign mid_cnt = fill_reg >> 1;

    always_comb begin
        fill_next    = fill_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        med_next     = med_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            med_next     = cell_value[mid_cnt[IDX_W-1:0]];
            m_valid_next = 1'b1;
            busy_next    = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            if (!full) begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        med_reg <= med_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = med_reg;

endmodule
